// ----- hw/rtl/gbp_pkg.sv -----
`timescale 1ns / 1ps

package gbp_pkg;

    localparam int TABLE_SIZE_DEF   = 2048;
    localparam int COUNTER_BITS_DEF = 2;
    localparam int THREADS_DEF      = 4;

    localparam int HIST_BITS    = 11;
    localparam int HIST_LEN_W   = 4;
    localparam int THREAD_ID_W  = 2;
    localparam int OP_W         = 3;
    localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = 4'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP   = 3'd0,
        OP_UPDATE   = 3'd1,
        OP_UNCOND   = 3'd2,
        OP_SQUASH   = 3'd3,
        OP_BTB_MISS = 3'd4
    } op_e;

    typedef struct packed {
        logic                   valid;
        logic [OP_W-1:0]        op;
        logic [THREAD_ID_W-1:0] tid;
        logic                   thread_ok;
        logic                   taken;
        logic                   squashed;
    } hist_req_t;

    function automatic logic [HIST_BITS-1:0] hist_mask(input logic [HIST_LEN_W-1:0] len);
        logic [HIST_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < HIST_BITS; i++) begin
            m[i] = (32'(len) > i);
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/gbp_hist.sv -----
`timescale 1ns / 1ps

module gbp_hist #(
    parameter int THREADS = gbp_pkg::THREADS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gbp_pkg::HIST_LEN_W-1:0]      cfg_wdata,
    input  gbp_pkg::hist_req_t                  req,
    output logic [gbp_pkg::HIST_BITS-1:0]       hist_cur
);

    localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;

    logic [gbp_pkg::HIST_LEN_W-1:0] hist_len_reg;
    logic [gbp_pkg::HIST_BITS-1:0]  global_reg [THREADS];
    logic [gbp_pkg::HIST_BITS-1:0]  saved_reg  [THREADS];
    logic [gbp_pkg::HIST_BITS-1:0]  mask;
    logic [gbp_pkg::HIST_BITS-1:0]  glob_cur;
    logic [gbp_pkg::HIST_BITS-1:0]  saved_cur;
    logic [TID_W-1:0]               tid_idx;

    assign tid_idx   = TID_W'(req.tid);
    assign glob_cur  = req.thread_ok ? global_reg[tid_idx] : '0;
    assign saved_cur = req.thread_ok ? saved_reg[tid_idx] : '0;
    assign hist_cur  = glob_cur;
    assign mask      = gbp_pkg::hist_mask(hist_len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_len_reg <= gbp_pkg::HIST_LEN_RESET;
        end else if (cfg_we) begin
            hist_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < THREADS; t++) begin
                global_reg[t] <= '0;
                saved_reg[t]  <= '0;
            end
        end else if (req.valid && req.thread_ok) begin
            unique case (req.op)
                gbp_pkg::OP_LOOKUP: begin
                    saved_reg[tid_idx] <= glob_cur;
                end
                gbp_pkg::OP_UPDATE: begin
                    if (req.squashed) begin
                        global_reg[tid_idx] <= {saved_cur[gbp_pkg::HIST_BITS-2:0], req.taken}
                                               & mask;
                    end
                end
                gbp_pkg::OP_UNCOND: begin
                    saved_reg[tid_idx]  <= glob_cur;
                    global_reg[tid_idx] <= {glob_cur[gbp_pkg::HIST_BITS-2:0], 1'b1} & mask;
                end
                gbp_pkg::OP_SQUASH: begin
                    global_reg[tid_idx] <= saved_cur;
                    saved_reg[tid_idx]  <= '0;
                end
                gbp_pkg::OP_BTB_MISS: begin
                    global_reg[tid_idx] <= glob_cur & mask
                                           & ~gbp_pkg::HIST_BITS'(1);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/gbp_table.sv -----
`timescale 1ns / 1ps

module gbp_table #(
    parameter int TABLE_SIZE   = gbp_pkg::TABLE_SIZE_DEF,
    parameter int COUNTER_BITS = gbp_pkg::COUNTER_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]   rd_idx,
    output logic [COUNTER_BITS-1:0]         rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]   wr_idx,
    input  logic [COUNTER_BITS-1:0]         wr_data,
    output logic                            busy
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [COUNTER_BITS-1:0] mem [TABLE_SIZE];
    logic [COUNTER_BITS-1:0] rd_data_reg;
    logic                    clr_reg;
    logic [IDX_W-1:0]        clr_addr_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [COUNTER_BITS-1:0] mem_wdata;

    assign busy      = clr_reg;
    assign rd_data   = rd_data_reg;
    assign mem_we    = clr_reg || wr_en;
    assign mem_waddr = clr_reg ? clr_addr_reg : wr_idx;
    assign mem_wdata = clr_reg ? '0 : wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_reg) begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(TABLE_SIZE - 1)) begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

endmodule

// ----- hw/rtl/gshare_branch_predictor_unit.sv -----
`timescale 1ns / 1ps

// Gshare branch predictor with a global history per hardware thread.
// The s_axis channel carries one operation per transaction: tuser selects
// lookup, update, unconditional branch, squash or BTB miss, and tdata holds
// the thread, branch address, resolved outcome and squash flag. Every
// transaction produces exactly one m_axis transaction whose tdata bit 0 is
// the prediction (counter MSB for a lookup on a valid thread, zero otherwise).
// An accepted transaction passes the read stage and then the output register.
// One transaction is accepted per cycle unless stalled; the counter memory
// is read in the accept cycle and written back as the item leaves the read
// stage, and a write to the entry the next item reads bypasses the memory.
// After reset the counter memory is cleared one entry per cycle, covering all
// TABLE_SIZE entries (2048 by default); s_axis_tready stays low meanwhile.
// cfg_we writes the history length and may be used at any time.
// When the receiver holds m_axis_tready low, the result waits in the output
// register, one more item waits in the read stage, and s_axis_tready drops.

module gshare_branch_predictor_unit #(
    parameter int TABLE_SIZE   = gbp_pkg::TABLE_SIZE_DEF,
    parameter int COUNTER_BITS = gbp_pkg::COUNTER_BITS_DEF,
    parameter int THREADS      = gbp_pkg::THREADS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // thread_id[1:0], pc[33:2], taken[34], squashed[35], zero[39:36]
    input  logic [39:0] s_axis_tdata,
    // op[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // predict_taken[0], zero[7:1]
    output logic [7:0]  m_axis_tdata
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [gbp_pkg::THREAD_ID_W-1:0] in_tid;
    logic [31:0]                     in_addr;
    logic                            in_taken;
    logic                            in_squashed;
    logic                            in_fire;
    logic                            thread_ok;
    logic                            is_lookup;
    logic                            is_train;
    gbp_pkg::hist_req_t              hreq;
    logic [gbp_pkg::HIST_BITS-1:0]   hist_cur;
    logic [IDX_W-1:0]                rd_idx;
    logic                            tbl_busy;
    logic [COUNTER_BITS-1:0]         tbl_rd_data;

    logic                    s1_valid_reg;
    logic                    s1_lookup_reg;
    logic                    s1_train_reg;
    logic                    s1_taken_reg;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic                    s1_fwd_reg;
    logic [COUNTER_BITS-1:0] fwd_data_reg;
    logic                    s1_adv;
    logic                    wr_fire;
    logic [COUNTER_BITS-1:0] ctr_cur;
    logic [COUNTER_BITS-1:0] ctr_next;

    logic m_valid_reg;
    logic m_pred_reg;

    assign in_tid      = s_axis_tdata[1:0];
    assign in_addr     = s_axis_tdata[33:2];
    assign in_taken    = s_axis_tdata[34];
    assign in_squashed = s_axis_tdata[35];

    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !tbl_busy && (!s1_valid_reg || s1_adv);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign thread_ok = (32'(in_tid) < THREADS);
    assign is_lookup = thread_ok && (s_axis_tuser == gbp_pkg::OP_LOOKUP);
    assign is_train  = thread_ok && (s_axis_tuser == gbp_pkg::OP_UPDATE) && !in_squashed;

    always_comb begin
        hreq.valid     = in_fire;
        hreq.op        = s_axis_tuser;
        hreq.tid       = in_tid;
        hreq.thread_ok = thread_ok;
        hreq.taken     = in_taken;
        hreq.squashed  = in_squashed;
    end

    gbp_hist #(
        .THREADS (THREADS)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (hreq),
        .hist_cur  (hist_cur)
    );

    assign rd_idx = IDX_W'(in_addr) ^ IDX_W'(hist_cur);

    assign wr_fire = s1_adv && s1_train_reg;
    assign ctr_cur = s1_fwd_reg ? fwd_data_reg : tbl_rd_data;

    always_comb begin
        ctr_next = ctr_cur;
        if (s1_taken_reg) begin
            if (ctr_cur != {COUNTER_BITS{1'b1}}) begin
                ctr_next = ctr_cur + COUNTER_BITS'(1);
            end
        end else begin
            if (ctr_cur != '0) begin
                ctr_next = ctr_cur - COUNTER_BITS'(1);
            end
        end
    end

    gbp_table #(
        .TABLE_SIZE   (TABLE_SIZE),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_fire && (is_lookup || is_train)),
        .rd_idx  (rd_idx),
        .rd_data (tbl_rd_data),
        .wr_en   (wr_fire),
        .wr_idx  (s1_idx_reg),
        .wr_data (ctr_next),
        .busy    (tbl_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_lookup_reg <= is_lookup;
            s1_train_reg  <= is_train;
            s1_taken_reg  <= in_taken;
            s1_idx_reg    <= rd_idx;
            s1_fwd_reg    <= wr_fire && (s1_idx_reg == rd_idx);
        end
        if (wr_fire) begin
            fwd_data_reg <= ctr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_pred_reg <= s1_lookup_reg && ctr_cur[COUNTER_BITS-1];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_pred_reg};

endmodule

// ----- hw/rtl/gbp_checker.sv -----
`timescale 1ns / 1ps

module gbp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // The counter memory is being cleared right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("input accepted during the clearing pass");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A result that appears on an idle output stems from an accepted input transaction.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input transaction");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("result padding bits are not zero");

endmodule

bind gshare_branch_predictor_unit gbp_checker u_gbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
